[rtl/core/ircs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ircs_pkg
// Shared types, byte codes and helpers for the formatting code stripper.
// ----------------------------------------------------------------------------
package ircs_pkg;

	// Byte codes that matter to the filter
	localparam logic [7:0] BYTE_COLOUR = 8'd3;
	localparam logic [7:0] BYTE_COMMA  = 8'h2C;
	localparam logic [7:0] BYTE_SPACE  = 8'd32;
	localparam logic [7:0] BYTE_HIGH   = 8'd128;

	// Reset value of the keep-high-bytes mode register
	localparam logic KEEP_HIGH_RESET = 1'b0;

	// Position inside a colour code
	typedef enum logic [2:0] {
		PH_NORMAL      = 3'd0,
		PH_AFTER_C     = 3'd1,
		PH_ONE_DIGIT   = 3'd2,
		PH_TWO_DIGITS  = 3'd3,
		PH_AFTER_COMMA = 3'd4,
		PH_BG_DIGIT    = 3'd5
	} ircs_phase_t;

	// One result item on its way to the output register
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       has_byte;
		logic       eos;
	} ircs_result_t;

	// Decimal digit test
	function automatic logic is_digit(input logic [7:0] b);
		return b inside {[8'h30:8'h39]};
	endfunction

endpackage
`default_nettype wire

[rtl/core/ircs_filter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ircs_filter
// Colour phase register and the byte classifier. Builds the result for the
// item held in the input register and moves the phase when it advances.
// ----------------------------------------------------------------------------
module ircs_filter (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   adv,
	input  wire  [7:0]            byte_s1,
	input  wire                   last_s1,
	input  wire                   keep_high,
	output ircs_pkg::ircs_result_t res
);
	import ircs_pkg::*;

	ircs_phase_t phase_q;
	ircs_phase_t phase_next;
	ircs_phase_t normal_next;
	logic        swallowed;
	logic        normal_kept;
	logic        kept;

	// Judgement of the byte as plain text
	always_comb begin
		normal_next = PH_NORMAL;
		normal_kept = 1'b1;
		if (byte_s1 == BYTE_COLOUR) begin
			normal_next = PH_AFTER_C;
			normal_kept = 1'b0;
		end else if (byte_s1 < BYTE_SPACE) begin
			normal_kept = 1'b0;
		end else if (byte_s1 >= BYTE_HIGH) begin
			normal_kept = keep_high;
		end
	end

	// Colour code tracking
	always_comb begin
		phase_next = PH_NORMAL;
		swallowed  = 1'b0;
		case (phase_q)
			PH_AFTER_C: begin
				if (is_digit(byte_s1)) begin
					phase_next = PH_ONE_DIGIT;
					swallowed  = 1'b1;
				end
			end
			PH_ONE_DIGIT: begin
				if (is_digit(byte_s1)) begin
					phase_next = PH_TWO_DIGITS;
					swallowed  = 1'b1;
				end else if (byte_s1 == BYTE_COMMA) begin
					phase_next = PH_AFTER_COMMA;
					swallowed  = 1'b1;
				end
			end
			PH_TWO_DIGITS: begin
				if (byte_s1 == BYTE_COMMA) begin
					phase_next = PH_AFTER_COMMA;
					swallowed  = 1'b1;
				end
			end
			PH_AFTER_COMMA: begin
				if (is_digit(byte_s1)) begin
					phase_next = PH_BG_DIGIT;
					swallowed  = 1'b1;
				end
			end
			PH_BG_DIGIT: begin
				if (is_digit(byte_s1)) begin
					phase_next = PH_NORMAL;
					swallowed  = 1'b1;
				end
			end
			default: begin
				phase_next = PH_NORMAL;
			end
		endcase
		// a byte that breaks the code is judged as plain text
		if (!swallowed) begin
			phase_next = normal_next;
		end
	end

	assign kept = !swallowed && normal_kept;

	// Result for the item in the input register
	always_comb begin
		res.valid    = kept || last_s1;
		res.data     = kept ? byte_s1 : 8'd0;
		res.has_byte = kept;
		res.eos      = last_s1;
	end

	// Phase register; the end of a string returns to plain text
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_NORMAL;
		end else if (adv) begin
			phase_q <= last_s1 ? PH_NORMAL : phase_next;
		end
	end

`ifndef SYNTH
	a_last_resets_phase: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> phase_q == PH_NORMAL)
		else $error("colour phase survived the end of a string");

	a_high_dropped: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !keep_high && byte_s1[7] |-> !res.has_byte)
		else $error("high byte kept while mode drops it");
`endif

endmodule
`default_nettype wire

[rtl/core/ircs_out_reg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ircs_out_reg
// Result register. Holds one result item until the sink takes it and tells
// the input side whether a new result can be loaded.
// ----------------------------------------------------------------------------
module ircs_out_reg (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   load,
	input  wire ircs_pkg::ircs_result_t res,
	input  wire                   out_stall,
	output logic                  room,
	output logic                  out_valid,
	output logic [7:0]            out_byte,
	output logic                  has_byte,
	output logic                  end_of_string
);
	import ircs_pkg::*;

	logic       valid_q;
	logic [7:0] data_q;
	logic       has_byte_q;
	logic       eos_q;

	// Free, or emptied in this cycle
	assign room = !valid_q || !out_stall;

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= load;
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (room && load) begin
			data_q     <= res.data;
			has_byte_q <= res.has_byte;
			eos_q      <= res.eos;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = data_q;
	assign has_byte      = has_byte_q;
	assign end_of_string = eos_q;

endmodule
`default_nettype wire

[rtl/core/irc_control_code_stripper_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// irc_control_code_stripper_top
// Removes chat formatting codes from a text byte stream.
// ----------------------------------------------------------------------------
// Takes one byte item per cycle and gives at most one result item for it:
// the byte is held in an input register, judged against the colour phase
// register, and the result lands in an output register. A result comes for
// a kept byte, or for the last byte of a string (end_of_string set, has_byte
// clear if the byte was dropped). The sustained rate is one item per cycle
// while the sink takes results; stall on the output pushes straight back to
// in_stall through the output register. The user must write keep_high_bytes
// through cfg_valid/cfg_data only while idle; the block does not enforce it.
module irc_control_code_stripper_top (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_stall,
	input  wire  [7:0] in_byte,
	input  wire        in_last,
	output logic       out_valid,
	input  wire        out_stall,
	output logic [7:0] out_byte,
	output logic       has_byte,
	output logic       end_of_string,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire        cfg_data
);
	import ircs_pkg::*;

	logic         keep_q;
	logic         valid_s1;
	logic [7:0]   byte_s1;
	logic         last_s1;
	logic         room;
	logic         adv;
	logic         accept;
	ircs_result_t res;

	// Mode register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			keep_q <= cfg_data;
		end
	end

	// Handshake: the input register moves on when the output has room
	assign adv      = valid_s1 && room;
	assign in_stall = valid_s1 && !room;
	assign accept   = in_valid && !in_stall;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	ircs_filter u_filter (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.byte_s1   (byte_s1),
		.last_s1   (last_s1),
		.keep_high (keep_q),
		.res       (res)
	);

	ircs_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (adv && res.valid),
		.res           (res),
		.out_stall     (out_stall),
		.room          (room),
		.out_valid     (out_valid),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.end_of_string (end_of_string)
	);

`ifndef SYNTH
	a_result_has_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> has_byte || end_of_string)
		else $error("result with neither byte nor end mark");

	a_empty_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_byte |-> out_byte == 8'd0)
		else $error("dropped byte leaked onto out_byte");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire

[bench/strip_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strip_result_checker
// Watches both channels and the mode write port of the formatting code
// stripper. It predicts the cleaned text from each accepted input item and
// compares every accepted result item with the oldest prediction waiting.
// ----------------------------------------------------------------------------
module strip_result_checker (
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	input  wire       in_stall,
	input  wire [7:0] in_byte,
	input  wire       in_last,
	input  wire       out_valid,
	input  wire       out_stall,
	input  wire [7:0] out_byte,
	input  wire       has_byte,
	input  wire       end_of_string,
	input  wire       cfg_valid,
	input  wire       cfg_ready,
	input  wire       cfg_data,
	output int        mismatches,
	output int        pending
);
	import ircs_pkg::*;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam int         REPORT_LIMIT = 10;

	typedef struct packed {
		logic [7:0] data;
		logic       kept;
		logic       eos;
	} clean_result_t;

	// Own copy of the stripper state
	ircs_phase_t   colour_phase;
	logic          keep_high;
	clean_result_t cleaned_q[$];
	int            err_count = 0;

	// Judge one accepted byte and queue the result item it causes
	task automatic judge_byte(input logic [7:0] b, input logic last);
		ircs_phase_t   nxt;
		logic          swallowed;
		logic          kept;
		logic          digit;
		clean_result_t res;
		nxt       = PH_NORMAL;
		swallowed = 1'b0;
		kept      = 1'b0;
		digit     = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
		case (colour_phase)
			PH_AFTER_C: if (digit) begin
				nxt       = PH_ONE_DIGIT;
				swallowed = 1'b1;
			end
			PH_ONE_DIGIT: if (digit) begin
				nxt       = PH_TWO_DIGITS;
				swallowed = 1'b1;
			end else if (b == BYTE_COMMA) begin
				nxt       = PH_AFTER_COMMA;
				swallowed = 1'b1;
			end
			PH_TWO_DIGITS: if (b == BYTE_COMMA) begin
				nxt       = PH_AFTER_COMMA;
				swallowed = 1'b1;
			end
			PH_AFTER_COMMA: if (digit) begin
				nxt       = PH_BG_DIGIT;
				swallowed = 1'b1;
			end
			PH_BG_DIGIT: if (digit) begin
				nxt       = PH_NORMAL;
				swallowed = 1'b1;
			end
			default: ;
		endcase
		// a byte that breaks the code is judged as plain text
		if (!swallowed) begin
			if (b == BYTE_COLOUR)
				nxt = PH_AFTER_C;
			else if (b >= BYTE_SPACE)
				kept = (b < BYTE_HIGH) || keep_high;
		end
		// a colour code never runs across strings
		colour_phase = last ? PH_NORMAL : nxt;
		if (kept || last) begin
			res.data = kept ? b : 8'd0;
			res.kept = kept;
			res.eos  = last;
			cleaned_q.push_back(res);
		end
	endtask

	// Compare one accepted result item with the oldest prediction
	task automatic check_result();
		clean_result_t want;
		if (cleaned_q.size() == 0) begin
			err_count++;
			if (err_count <= REPORT_LIMIT)
				$display("mismatch at %0t: result byte %h has_byte %b end %b, none expected",
					$time, out_byte, has_byte, end_of_string);
		end else begin
			want = cleaned_q.pop_front();
			if (out_byte !== want.data || has_byte !== want.kept ||
				end_of_string !== want.eos) begin
				err_count++;
				if (err_count <= REPORT_LIMIT)
					$display("mismatch at %0t: expected byte %h has_byte %b end %b, got %h %b %b",
						$time, want.data, want.kept, want.eos,
						out_byte, has_byte, end_of_string);
			end
		end
	endtask

	// Results are checked before the input of the same edge is queued
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			colour_phase = PH_NORMAL;
			keep_high    = KEEP_HIGH_RESET;
			cleaned_q.delete();
			mismatches   <= err_count;
			pending      <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				keep_high = cfg_data;
			if (out_valid && !out_stall)
				check_result();
			if (in_valid && !in_stall)
				judge_byte(in_byte, in_last);
			mismatches <= err_count;
			pending    <= cleaned_q.size();
		end
	end

endmodule

[bench/irc_control_code_stripper_top_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// irc_control_code_stripper_top_test
// Drives text strings through the formatting code stripper: a directed run
// over control bytes, high bytes and colour codes, then random strings made
// mostly of text and well-formed colour codes, under changing idle and stall
// rates and both settings of the keep-high-bytes mode. A separate checker
// predicts and compares; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module irc_control_code_stripper_top_test;
	import ircs_pkg::*;

	localparam int         WATCHDOG_LIMIT = 4000;
	localparam int         HOLD_CYCLES    = 300;
	localparam int         SETTLE_CYCLES  = 4;
	localparam logic [7:0] CHAR_ZERO      = 8'h30;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic [7:0] in_byte   = 8'd0;
	logic       in_last   = 1'b0;
	logic       out_stall = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_data  = 1'b0;
	wire        in_stall;
	wire        out_valid;
	wire  [7:0] out_byte;
	wire        has_byte;
	wire        end_of_string;
	wire        cfg_ready;
	int         mismatches;
	int         pending;

	int   idle_pct    = 0;
	int   stall_pct   = 0;
	logic hold_token  = 1'b0;
	logic hold_seen   = 1'b0;
	int   hold_left   = 0;
	int   quiet_cycles = 0;
	int   bytes_sent  = 0;

	irc_control_code_stripper_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.end_of_string (end_of_string),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	strip_result_checker result_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.in_byte       (in_byte),
		.in_last       (in_last),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.end_of_string (end_of_string),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// Clock
	initial begin
		forever #1 clk = ~clk;
	end

	// Receiver: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else
			out_stall <= ($urandom_range(99) < stall_pct);
	end

	// Watchdog: cycles in a row with no item moving anywhere
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	// Offer one byte item, with random idle cycles before it
	task automatic send_item(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte  <= b;
		in_last  <= last;
		do
			@(posedge clk);
		while (in_stall);
		bytes_sent++;
	endtask

	// Stop offering and wait until every predicted result has arrived
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the mode register; only called while the block is idle
	task automatic write_keep_high(input logic v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// One random string, mostly text and well-formed colour codes
	task automatic send_string();
		logic [7:0] text[$];
		int         len;
		int         n;
		len = $urandom_range(1, 12);
		while (text.size() < len) begin
			case ($urandom_range(9))
				0, 1, 2, 3: text.push_back(8'($urandom_range(32, 127)));
				4, 5: begin
					text.push_back(BYTE_COLOUR);
					n = $urandom_range(0, 2);
					repeat (n) text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
					if ($urandom_range(1)) begin
						text.push_back(BYTE_COMMA);
						repeat ($urandom_range(0, 2))
							text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
					end
				end
				6: text.push_back(8'($urandom_range(0, 31)));
				7: text.push_back(8'($urandom_range(128, 255)));
				8: text.push_back($urandom_range(1) ? BYTE_COMMA : CHAR_ZERO + 8'($urandom_range(9)));
				default: text.push_back(8'($urandom_range(255)));
			endcase
		end
		for (int i = 0; i < text.size(); i++)
			send_item(text[i], i == text.size() - 1);
	endtask

	// Stimulus and verdict
	initial begin
		logic held;
		held = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: printable edges, control bytes, high bytes dropped
		send_item("A", 1'b0);
		send_item(BYTE_SPACE, 1'b0);
		send_item(8'h7F, 1'b0);
		send_item(8'd0, 1'b0);
		send_item(8'd1, 1'b0);
		send_item(8'd2, 1'b0);
		send_item(8'd9, 1'b0);
		send_item(8'd10, 1'b0);
		send_item(8'd13, 1'b0);
		send_item(8'd22, 1'b0);
		send_item(8'd31, 1'b0);
		send_item(BYTE_HIGH, 1'b0);
		send_item(8'hFF, 1'b0);
		// full colour code with background
		send_item(BYTE_COLOUR, 1'b0);
		send_item("1", 1'b0);
		send_item("2", 1'b0);
		send_item(BYTE_COMMA, 1'b0);
		send_item("3", 1'b0);
		send_item("4", 1'b0);
		// comma straight after the colour byte is plain text
		send_item(BYTE_COLOUR, 1'b0);
		send_item(BYTE_COMMA, 1'b0);
		// colour byte breaks a code and opens a new one; dropped last byte
		send_item(BYTE_COLOUR, 1'b0);
		send_item("7", 1'b0);
		send_item(BYTE_COLOUR, 1'b1);
		// digit after a string end is not swallowed
		send_item("5", 1'b1);
		drain();
		write_keep_high(1'b1);
		send_item(BYTE_HIGH, 1'b0);
		send_item(8'hFF, 1'b1);
		drain();

		// random: sender idles a little, receiver stalls a lot
		write_keep_high(1'b0);
		idle_pct = 9;
		stall_pct <= 79;
		while (bytes_sent < 340) begin
			send_string();
			if (!held && bytes_sent > 160) begin
				hold_token <= ~hold_token;
				held = 1'b1;
			end
		end
		drain();

		// the other way round, high bytes kept, with one full pause
		write_keep_high(1'b1);
		idle_pct = 79;
		stall_pct <= 9;
		held = 1'b0;
		while (bytes_sent < 650) begin
			send_string();
			if (!held && bytes_sent > 480) begin
				drain();
				held = 1'b1;
			end
		end
		drain();

		// no idling at all
		write_keep_high(1'b0);
		idle_pct = 0;
		stall_pct <= 0;
		while (bytes_sent < 980)
			send_string();
		drain();
		repeat (8) @(posedge clk);

		if (mismatches == 0 && pending == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
